// ===== sv/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared opcodes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int DEP_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_PUSH,
    CM_POP
  } commit_t;

  typedef struct packed {
    logic            load;
    logic            rd;
    logic            mul_go;
    logic            div_init;
    logic            div_step;
    logic            done;
    commit_t         commit;
    logic [ST_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            lt2;
    logic            top_zero;
    logic            div_last;
  } dp_sts_t;

endpackage

// ===== sv/rpn_dp.sv =====
// ----------------------------------------------------------------------------
// rpn_dp
// Operand stack datapath: top-of-stack register, stack memory below it,
// add/sub, registered multiplier and radix-2 restoring divider.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpn_pkg::dp_cmd_t                    cmd,
  output rpn_pkg::dp_sts_t                    sts,
  input  logic [rpn_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [rpn_pkg::DATA_W-1:0]   in_operand,
  output logic                                out_valid,
  output logic signed [rpn_pkg::DATA_W-1:0]   out_top_value,
  output logic [rpn_pkg::DEP_W-1:0]           out_depth,
  output logic [rpn_pkg::ST_W-1:0]            out_status
);
  import rpn_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DCW = $clog2(DATA_W);

  // entries below the top; the top lives in top_r
  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]     count_r;
  logic [DATA_W-1:0] top_r;
  logic [DATA_W-1:0] second_r;
  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] operand_r;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] dm_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] rem_r;
  logic              qneg_r;
  logic [DCW-1:0]    div_cnt_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   status_r;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] rem_nxt;
  logic [DATA_W-1:0] quo_nxt;
  logic [DATA_W-1:0] pop_res;
  logic [DATA_W-1:0] top_mag;
  logic [DATA_W-1:0] sec_mag;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);

  assign sts.op       = op_r;
  assign sts.full     = (count_r >= CW'(STACK_DEPTH));
  assign sts.lt2      = (count_r < CW'(2));
  assign sts.top_zero = (top_r == '0);
  assign sts.div_last = (div_cnt_r == {DCW{1'b1}});

  assign top_mag = top_r[DATA_W-1]    ? (DATA_W'(0) - top_r)    : top_r;
  assign sec_mag = second_r[DATA_W-1] ? (DATA_W'(0) - second_r) : second_r;

  // one restoring divide step
  always_comb begin
    trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, dm_r};
    if (!trial[DATA_W]) begin
      rem_nxt = trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  always_comb begin
    case (op_r)
      OP_ADD:  pop_res = second_r + top_r;
      OP_SUB:  pop_res = second_r - top_r;
      OP_MUL:  pop_res = prod_r;
      OP_DIV:  pop_res = qneg_r ? (DATA_W'(0) - quo_r) : quo_r;
      default: pop_res = top_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
      if (cmd.done) begin
        case (cmd.commit)
          CM_PUSH: count_r <= count_r + CW'(1);
          CM_POP:  count_r <= cnt_m1;
          default: count_r <= count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      operand_r <= in_operand;
    end
    if (cmd.rd) begin
      second_r <= mem[cnt_m2[AW-1:0]];
    end
    if (cmd.mul_go) begin
      prod_r <= DATA_W'(second_r * top_r);
    end
    if (cmd.div_init) begin
      dm_r      <= top_mag;
      quo_r     <= sec_mag;
      rem_r     <= '0;
      qneg_r    <= second_r[DATA_W-1] ^ top_r[DATA_W-1];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      quo_r     <= quo_nxt;
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
    if (cmd.done) begin
      status_r <= cmd.status;
      case (cmd.commit)
        CM_PUSH: begin
          // old top sinks into the memory
          if (count_r != '0) begin
            mem[cnt_m1[AW-1:0]] <= top_r;
          end
          top_r <= operand_r;
        end
        CM_POP:  top_r <= pop_res;
        default: top_r <= top_r;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = (count_r == '0) ? '0 : top_r;
  assign out_depth     = DEP_W'(count_r);
  assign out_status    = status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.done && cmd.commit == CM_PUSH) |-> !sts.full)
    else $error("push committed on a full stack");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_divz_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_DIVZ) |-> count_r == $past(count_r))
    else $error("divide by zero changed the stack");

  a_pop_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.done && cmd.commit == CM_POP) |-> !sts.lt2)
    else $error("pop committed with fewer than two entries");
`endif

endmodule

// ===== sv/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpn_ctrl
// Sequencer: decodes the request, checks stack limits and drives the
// datapath through read, multiply or divide iterations and commit.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rpn_pkg::dp_sts_t sts,
  output rpn_pkg::dp_cmd_t cmd
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPER,
    S_MULW,
    S_DIV,
    S_DIVF
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op) inside
          OP_PUSH: begin
            cmd.done   = 1'b1;
            cmd.commit = sts.full ? CM_HOLD : CM_PUSH;
            cmd.status = sts.full ? ST_OVER : ST_OK;
            state_nxt  = S_IDLE;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (sts.lt2) begin
              cmd.done   = 1'b1;
              cmd.commit = CM_HOLD;
              cmd.status = ST_UNDER;
              state_nxt  = S_IDLE;
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = S_OPER;
            end
          end
          default: begin
            // unused opcodes: report, no change
            cmd.done   = 1'b1;
            cmd.commit = CM_HOLD;
            cmd.status = ST_OK;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_OPER: begin
        case (sts.op)
          OP_MUL: begin
            cmd.mul_go = 1'b1;
            state_nxt  = S_MULW;
          end
          OP_DIV: begin
            if (sts.top_zero) begin
              cmd.done   = 1'b1;
              cmd.commit = CM_HOLD;
              cmd.status = ST_DIVZ;
              state_nxt  = S_IDLE;
            end else begin
              cmd.div_init = 1'b1;
              state_nxt    = S_DIV;
            end
          end
          default: begin
            cmd.done   = 1'b1;
            cmd.commit = CM_POP;
            cmd.status = ST_OK;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_MULW, S_DIVF: begin
        cmd.done   = 1'b1;
        cmd.commit = CM_POP;
        cmd.status = ST_OK;
        state_nxt  = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DIVF;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

`ifndef SYNTHESIS
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy out of step with sequencer");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DECODE)
    else $error("request load did not enter decode");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> state_r == S_DIVF)
    else $error("divide did not finish after last step");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> !busy_r)
    else $error("still busy after commit");
`endif

endmodule

// ===== sv/rpn_stack_calculator.sv =====
// Commit: push, invalid opcode, underflow in S_DECODE; add/sub, divide by zero
//   in S_OPER; multiply in S_MULW; divide in S_DIVF after 32 radix-2 steps.
// Throughput: one request at a time; busy stays high until the result cycle,
//   so a new request may be accepted while out_valid is shown.
// Reset (rst_n low, synchronous): stack empty, controller idle, no strobe.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse-Polish calculator on a stack of signed 32-bit words.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rpn_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [rpn_pkg::DATA_W-1:0]   in_operand,
  output logic                                out_valid,
  output logic signed [rpn_pkg::DATA_W-1:0]   out_top_value,
  output logic [rpn_pkg::DEP_W-1:0]           out_depth,
  output logic [rpn_pkg::ST_W-1:0]            out_status
);
  import rpn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_opcode),
    .in_operand    (in_operand),
    .out_valid     (out_valid),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_status    (out_status)
  );

endmodule
